@@ hw/rtl/jfd_pkg.sv @@
// Shared types and constants for the JT808 frame deframer.
// Depends on nothing; every other file in this block imports it.
package jfd_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7e;
  localparam logic [7:0] ESC_BYTE     = 8'h7d;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;

  localparam int POS_W      = 11;
  localparam int LEN_W      = 10;
  localparam int ENC_BIT    = 10;
  localparam int SUBPKG_BIT = 13;

  // Frame positions, counted from 1 at the opening flag.
  localparam logic [POS_W-1:0] POS_HUNT      = 11'd0;
  localparam logic [POS_W-1:0] POS_FLAG      = 11'd1;
  localparam logic [POS_W-1:0] POS_ID_HI     = 11'd2;
  localparam logic [POS_W-1:0] POS_ID_LO     = 11'd3;
  localparam logic [POS_W-1:0] POS_PROPS_HI  = 11'd4;
  localparam logic [POS_W-1:0] POS_PROPS_LO  = 11'd5;
  localparam logic [POS_W-1:0] POS_TERM_0    = 11'd6;
  localparam logic [POS_W-1:0] POS_TERM_1    = 11'd7;
  localparam logic [POS_W-1:0] POS_TERM_2    = 11'd8;
  localparam logic [POS_W-1:0] POS_TERM_3    = 11'd9;
  localparam logic [POS_W-1:0] POS_TERM_4    = 11'd10;
  localparam logic [POS_W-1:0] POS_TERM_5    = 11'd11;
  localparam logic [POS_W-1:0] POS_SERIAL_HI = 11'd12;
  localparam logic [POS_W-1:0] POS_SERIAL_LO = 11'd13;
  localparam logic [POS_W-1:0] POS_COUNT_HI  = 11'd14;
  localparam logic [POS_W-1:0] POS_COUNT_LO  = 11'd15;
  localparam logic [POS_W-1:0] POS_INDEX_HI  = 11'd16;
  localparam logic [POS_W-1:0] POS_INDEX_LO  = 11'd17;
  // First position past the header (header length plus flag plus one).
  localparam logic [POS_W-1:0] SHORT_HDR_END = 11'd14;
  localparam logic [POS_W-1:0] LONG_HDR_END  = 11'd18;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Bad escape shares code 0 with the "no error" value of other kinds.
  typedef enum logic [1:0] {
    ERR_BAD_ESCAPE = 2'd0,
    ERR_CHECKSUM   = 2'd1,
    ERR_NO_KEY     = 2'd2
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  body_byte;
    err_t        error_code;
    logic [15:0] message_id;
    logic [15:0] message_props;
    logic        body_encrypted;
    logic [15:0] serial_number;
    logic [15:0] package_count;
    logic [15:0] package_index;
    logic [47:0] terminal_bcd;
  } result_t;

  localparam int TDATA_FIELDS_W = 139;
  localparam int TDATA_W        = 144;

  localparam logic [0:0] REG_KEY_LOADED = 1'b0;

endpackage

@@ hw/rtl/jfd_cfg.sv @@
// APB configuration register for the deframer: the key_loaded flag.
// Depends on jfd_pkg.
module jfd_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        key_loaded
);
  import jfd_pkg::*;

  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_KEY_LOADED[0]);
  assign wr_en  = psel & penable & pwrite & pready & hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_loaded <= 1'b0;
    end else if (wr_en) begin
      key_loaded <= pwdata[0];
    end
  end

  assign prdata = hit ? {31'd0, key_loaded} : 32'd0;

endmodule

@@ hw/rtl/jfd_parse.sv @@
// Deframer state and per-byte decode: flag hunt, unescape, checksum,
// header capture and result generation. Depends on jfd_pkg.
module jfd_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_loaded,
  input  logic             in_accept,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output jfd_pkg::result_t res
);
  import jfd_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic             esc, esc_next;
  logic [7:0]       xsum, xsum_next;
  logic             long_hdr, long_hdr_next;
  logic [15:0]      msg_id, msg_id_next;
  logic [15:0]      props, props_next;
  logic [47:0]      term, term_next;
  logic [15:0]      serial, serial_next;
  logic [15:0]      pkg_count, pkg_count_next;
  logic [15:0]      pkg_index, pkg_index_next;

  logic             step;
  logic             fail;
  err_t             fail_code;
  logic             open;
  logic [7:0]       ch;
  logic [POS_W-1:0] hdr_end;
  logic             hit_valid;
  kind_t            hit_kind;
  logic [7:0]       hit_body;

  always_comb begin
    pos_next       = pos;
    esc_next       = esc;
    xsum_next      = xsum;
    long_hdr_next  = long_hdr;
    msg_id_next    = msg_id;
    props_next     = props;
    term_next      = term;
    serial_next    = serial;
    pkg_count_next = pkg_count;
    pkg_index_next = pkg_index;
    step      = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_BAD_ESCAPE;
    open      = 1'b0;
    ch        = in_byte;
    hdr_end   = long_hdr ? LONG_HDR_END : SHORT_HDR_END;
    hit_valid = 1'b0;
    hit_kind  = KIND_BODY;
    hit_body  = 8'd0;

    if (pos == POS_HUNT) begin
      open = (in_byte == FLAG_BYTE);
    end else if (pos == POS_FLAG && !esc && in_byte == FLAG_BYTE) begin
      // skip repeated opening flags
    end else if (esc) begin
      esc_next = 1'b0;
      if (in_byte == ESC_FOR_ESC) begin
        ch   = ESC_BYTE;
        step = 1'b1;
      end else if (in_byte == ESC_FOR_FLAG) begin
        ch   = FLAG_BYTE;
        step = 1'b1;
      end else begin
        fail      = 1'b1;
        fail_code = ERR_BAD_ESCAPE;
      end
    end else if (in_byte == ESC_BYTE) begin
      esc_next = 1'b1;
    end else begin
      step = 1'b1;
    end

    if (step) begin
      xsum_next = xsum ^ ch;
      pos_next  = pos + 1'b1;
      if (pos_next < hdr_end) begin
        unique case (pos_next)
          POS_ID_HI:     msg_id_next = {ch, 8'd0};
          POS_ID_LO:     msg_id_next = {msg_id[15:8], ch};
          POS_PROPS_HI:  props_next  = {ch, 8'd0};
          POS_PROPS_LO: begin
            props_next = {props[15:8], ch};
            if (props_next[ENC_BIT] && !key_loaded) begin
              fail      = 1'b1;
              fail_code = ERR_NO_KEY;
            end else if (props_next[SUBPKG_BIT]) begin
              long_hdr_next = 1'b1;
            end
          end
          POS_TERM_0:    term_next[47:40] = ch;
          POS_TERM_1:    term_next[39:32] = ch;
          POS_TERM_2:    term_next[31:24] = ch;
          POS_TERM_3:    term_next[23:16] = ch;
          POS_TERM_4:    term_next[15:8]  = ch;
          POS_TERM_5:    term_next[7:0]   = ch;
          POS_SERIAL_HI: serial_next    = {ch, 8'd0};
          POS_SERIAL_LO: serial_next    = {serial[15:8], ch};
          POS_COUNT_HI:  pkg_count_next = {ch, 8'd0};
          POS_COUNT_LO:  pkg_count_next = {pkg_count[15:8], ch};
          POS_INDEX_HI:  pkg_index_next = {ch, 8'd0};
          POS_INDEX_LO:  pkg_index_next = {pkg_index[15:8], ch};
          default: ;
        endcase
      end else if (pos_next == hdr_end + {1'b0, props[LEN_W-1:0]}) begin
        // checksum byte closes the frame
        if (xsum_next != 8'd0) begin
          fail      = 1'b1;
          fail_code = ERR_CHECKSUM;
        end else begin
          hit_valid = 1'b1;
          hit_kind  = KIND_DONE;
          pos_next  = POS_HUNT;
        end
      end else begin
        hit_valid = 1'b1;
        hit_kind  = KIND_BODY;
        hit_body  = ch;
      end
    end

    // After an error, drop to hunting and look at this same byte again.
    if (fail) begin
      pos_next = POS_HUNT;
      esc_next = 1'b0;
      open     = (in_byte == FLAG_BYTE);
    end

    res_valid          = hit_valid | fail;
    res.kind           = fail ? KIND_ERROR : hit_kind;
    res.body_byte      = fail ? 8'd0 : hit_body;
    res.error_code     = fail ? fail_code : ERR_BAD_ESCAPE;
    res.message_id     = msg_id_next;
    res.message_props  = props_next;
    res.body_encrypted = props_next[ENC_BIT];
    res.serial_number  = serial_next;
    res.package_count  = pkg_count_next;
    res.package_index  = pkg_index_next;
    res.terminal_bcd   = term_next;

    if (open) begin
      pos_next       = POS_FLAG;
      esc_next       = 1'b0;
      xsum_next      = 8'd0;
      long_hdr_next  = 1'b0;
      pkg_count_next = 16'd0;
      pkg_index_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_HUNT;
      esc       <= 1'b0;
      xsum      <= 8'd0;
      long_hdr  <= 1'b0;
      msg_id    <= 16'd0;
      props     <= 16'd0;
      term      <= 48'd0;
      serial    <= 16'd0;
      pkg_count <= 16'd0;
      pkg_index <= 16'd0;
    end else if (in_accept) begin
      pos       <= pos_next;
      esc       <= esc_next;
      xsum      <= xsum_next;
      long_hdr  <= long_hdr_next;
      msg_id    <= msg_id_next;
      props     <= props_next;
      term      <= term_next;
      serial    <= serial_next;
      pkg_count <= pkg_count_next;
      pkg_index <= pkg_index_next;
    end
  end

  // An escape can only be pending inside a frame.
  a_esc_in_frame: assert property (@(posedge clk) disable iff (rst)
    esc |-> (pos != POS_HUNT))
    else $error("escape pending while hunting");

  // Position never runs past the longest legal frame.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= LONG_HDR_END + 11'd1023)
    else $error("frame position out of range");

endmodule

@@ hw/rtl/jfd_outq.sv @@
// Two-entry result queue between the decoder and the master stream side.
// Depends on jfd_pkg.
module jfd_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jfd_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output jfd_pkg::result_t out_data
);
  import jfd_pkg::*;

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;

  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid & out_ready;
  assign out_data  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("result pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2)
    else $error("queue count out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && cnt == 2'd1) |=> !out_valid)
    else $error("queue still valid after last entry taken");

endmodule

@@ hw/rtl/jt808_frame_deframer_top.sv @@
// JT808 frame deframer, top level: APB register, decoder and result queue.
// Depends on jfd_pkg, jfd_cfg, jfd_parse and jfd_outq.
//
// Takes one received byte per cycle on the slave stream and reports body
// bytes, frame-complete and error results on the master stream. Every byte
// is decoded in the cycle it is accepted and its result, if any, is registered
// and reaches m_tdata in order. A two-entry result queue decouples the
// sides: s_tready drops only while both entries hold results not yet taken,
// so with m_tready high the block sustains one byte per cycle. Write
// key_loaded (address 0) only while the stream is idle.
module jt808_frame_deframer_top (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] raw_byte
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] body_byte, [9:8] error_code, [25:10] message_id,
  // [41:26] message_props, [42] body_encrypted, [58:43] serial_number,
  // [74:59] package_count, [90:75] package_index, [138:91] terminal_bcd,
  // [143:139] zero
  output logic [143:0] m_tdata,
  output logic [1:0]   m_tuser,   // [1:0] kind
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import jfd_pkg::*;

  logic    key_loaded;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  logic    q_full;
  result_t q_data;

  jfd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_loaded (key_loaded)
  );

  assign s_tready  = ~q_full;
  assign in_accept = s_tvalid & s_tready;

  jfd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .key_loaded (key_loaded),
    .in_accept  (in_accept),
    .in_byte    (s_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  jfd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept & res_valid),
    .push_data (res),
    .full      (q_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_data)
  );

  assign m_tuser = q_data.kind;
  assign m_tdata = {{(TDATA_W - TDATA_FIELDS_W){1'b0}},
                    q_data.terminal_bcd,
                    q_data.package_index,
                    q_data.package_count,
                    q_data.serial_number,
                    q_data.body_encrypted,
                    q_data.message_props,
                    q_data.message_id,
                    q_data.error_code,
                    q_data.body_byte};

endmodule

@@ bench/jfd_checker.sv @@
// Scoreboard for the JT808 frame deframer: predicts results from accepted
// stream bytes and APB writes, then compares them against the master stream.
// Depends on jfd_pkg for the result layout, kinds, error codes and positions.
`timescale 1ns / 1ps

module jfd_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] raw_byte
  input  logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] body_byte, [9:8] error_code, [25:10] message_id,
  // [41:26] message_props, [42] body_encrypted, [58:43] serial_number,
  // [74:59] package_count, [90:75] package_index, [138:91] terminal_bcd
  input  logic [143:0] m_tdata,
  input  logic [1:0]   m_tuser,   // [1:0] kind
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending,
  output int           bytes_seen,
  output int           body_seen,
  output int           done_seen,
  output int           error_seen
);
  import jfd_pkg::*;

  // Non-error results carry code zero, which the package names as bad escape.
  localparam err_t NO_ERR = ERR_BAD_ESCAPE;

  result_t             expected_results[$];

  logic                key_on;
  logic [POS_W-1:0]    frame_pos;
  logic                esc_pend;
  logic [7:0]          xsum;
  logic                long_hdr;
  logic [15:0]         h_id;
  logic [15:0]         h_props;
  logic [15:0]         h_serial;
  logic [15:0]         h_count;
  logic [15:0]         h_index;
  logic [47:0]         h_term;

  function automatic string show(result_t r);
    return $sformatf({"kind=%0d body=%h err=%0d id=%h props=%h enc=%b",
                      " serial=%h cnt=%h idx=%h term=%h"},
                     r.kind, r.body_byte, r.error_code, r.message_id, r.message_props,
                     r.body_encrypted, r.serial_number, r.package_count, r.package_index,
                     r.terminal_bcd);
  endfunction

  task automatic note_mismatch(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  task automatic open_frame();
    frame_pos = POS_FLAG;
    esc_pend  = 1'b0;
    xsum      = 8'h00;
    long_hdr  = 1'b0;
    h_count   = 16'h0000;
    h_index   = 16'h0000;
  endtask

  task automatic post_result(kind_t k, logic [7:0] bb, err_t e);
    result_t r;
    r.kind           = k;
    r.body_byte      = bb;
    r.error_code     = e;
    r.message_id     = h_id;
    r.message_props  = h_props;
    r.body_encrypted = h_props[ENC_BIT];
    r.serial_number  = h_serial;
    r.package_count  = h_count;
    r.package_index  = h_index;
    r.terminal_bcd   = h_term;
    expected_results.push_back(r);
  endtask

  // Report the error, drop the frame and look at the same byte again.
  task automatic abort_frame(err_t e, logic [7:0] raw);
    post_result(KIND_ERROR, 8'h00, e);
    frame_pos = POS_HUNT;
    esc_pend  = 1'b0;
    if (raw == FLAG_BYTE) open_frame();
  endtask

  task automatic deframe_byte(logic [7:0] raw);
    logic [7:0]       ch;
    logic [POS_W-1:0] hdr_end;
    logic [POS_W-1:0] body_len;
    ch = raw;
    if (frame_pos == POS_HUNT) begin
      if (raw == FLAG_BYTE) open_frame();
      return;
    end
    // skip repeated opening flags
    if (frame_pos == POS_FLAG && !esc_pend && raw == FLAG_BYTE) return;
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (ch == ESC_FOR_ESC) ch = ESC_BYTE;
      else if (ch == ESC_FOR_FLAG) ch = FLAG_BYTE;
      else begin
        abort_frame(ERR_BAD_ESCAPE, raw);
        return;
      end
    end else if (ch == ESC_BYTE) begin
      esc_pend = 1'b1;
      return;
    end
    xsum      = xsum ^ ch;
    frame_pos = frame_pos + 1'b1;
    hdr_end   = long_hdr ? LONG_HDR_END : SHORT_HDR_END;
    if (frame_pos < hdr_end) begin
      case (frame_pos)
        POS_ID_HI:     h_id = {ch, 8'h00};
        POS_ID_LO:     h_id = h_id | {8'h00, ch};
        POS_PROPS_HI:  h_props = {ch, 8'h00};
        POS_PROPS_LO: begin
          h_props = h_props | {8'h00, ch};
          if (h_props[ENC_BIT] && !key_on) begin
            abort_frame(ERR_NO_KEY, raw);
            return;
          end
          if (h_props[SUBPKG_BIT]) long_hdr = 1'b1;
        end
        POS_TERM_0, POS_TERM_1, POS_TERM_2, POS_TERM_3, POS_TERM_4, POS_TERM_5:
          h_term[8 * (POS_TERM_5 - frame_pos) +: 8] = ch;
        POS_SERIAL_HI: h_serial = {ch, 8'h00};
        POS_SERIAL_LO: h_serial = h_serial | {8'h00, ch};
        POS_COUNT_HI:  h_count = {ch, 8'h00};
        POS_COUNT_LO:  h_count = h_count | {8'h00, ch};
        POS_INDEX_HI:  h_index = {ch, 8'h00};
        POS_INDEX_LO:  h_index = h_index | {8'h00, ch};
        default: ;
      endcase
      return;
    end
    body_len = {1'b0, h_props[LEN_W-1:0]};
    if (frame_pos == hdr_end + body_len) begin
      if (xsum != 8'h00) abort_frame(ERR_CHECKSUM, raw);
      else begin
        post_result(KIND_DONE, 8'h00, NO_ERR);
        frame_pos = POS_HUNT;
      end
    end else begin
      post_result(KIND_BODY, ch, NO_ERR);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      expected_results.delete();
      key_on     = 1'b0;
      frame_pos  = POS_HUNT;
      esc_pend   = 1'b0;
      xsum       = 8'h00;
      long_hdr   = 1'b0;
      h_id       = 16'h0000;
      h_props    = 16'h0000;
      h_serial   = 16'h0000;
      h_count    = 16'h0000;
      h_index    = 16'h0000;
      h_term     = 48'h0;
      fail_count = 0;
      bytes_seen = 0;
      body_seen  = 0;
      done_seen  = 0;
      error_seen = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == REG_KEY_LOADED[0]) begin
        if (pwrite) key_on = pwdata[0];
        else if (prdata[0] !== key_on)
          note_mismatch($sformatf("key_loaded read: expected %b, got %b", key_on, prdata[0]));
      end
      if (s_tvalid && s_tready) begin
        bytes_seen++;
        deframe_byte(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got.kind           = kind_t'(m_tuser);
        got.body_byte      = m_tdata[7:0];
        got.error_code     = err_t'(m_tdata[9:8]);
        got.message_id     = m_tdata[25:10];
        got.message_props  = m_tdata[41:26];
        got.body_encrypted = m_tdata[42];
        got.serial_number  = m_tdata[58:43];
        got.package_count  = m_tdata[74:59];
        got.package_index  = m_tdata[90:75];
        got.terminal_bcd   = m_tdata[138:91];
        if (expected_results.size() == 0) begin
          note_mismatch({"unexpected result: ", show(got)});
        end else begin
          want = expected_results.pop_front();
          case (want.kind)
            KIND_BODY: body_seen++;
            KIND_DONE: done_seen++;
            default:   error_seen++;
          endcase
          if (got !== want)
            note_mismatch({"result mismatch\n  expected ", show(want),
                           "\n  actual   ", show(got)});
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the JT808 deframer bench: clock, reset, APB writes and byte stimulus.
// Depends on jfd_pkg, jt808_frame_deframer_top and the jfd_checker scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import jfd_pkg::*;

  typedef enum int {FAULT_NONE, FAULT_CHECKSUM, FAULT_ESCAPE, FAULT_TRUNCATE} fault_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;   // [7:0] raw_byte
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;           // header fields and body byte, see the block
  logic [1:0]   m_tuser;           // [1:0] kind
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = 3'd0;
  logic [31:0]  pwdata = 32'h0;
  logic [31:0]  prdata;
  logic         pready;

  int fail_count;
  int pending;
  int bytes_seen;
  int body_seen;
  int done_seen;
  int error_seen;

  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;

  jt808_frame_deframer_top dut (.*);
  jfd_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  task automatic push_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic push_coded(logic [7:0] b);
    if (b == FLAG_BYTE) begin
      push_byte(ESC_BYTE);
      push_byte(ESC_FOR_FLAG);
    end else if (b == ESC_BYTE) begin
      push_byte(ESC_BYTE);
      push_byte(ESC_FOR_ESC);
    end else begin
      push_byte(b);
    end
  endtask

  // Hold the stream until every predicted result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'(REG_KEY_LOADED * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_key(logic v);
    drain();
    apb_access(1'b1, {31'h0, v});
    apb_access(1'b0, 32'h0);
    @(negedge clk);
  endtask

  function automatic logic [7:0] body_pick();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? FLAG_BYTE : ESC_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame(fault_t fault, logic [15:0] id, logic [15:0] props,
                            logic [47:0] term, logic [15:0] serial,
                            logic [15:0] pkg_cnt, logic [15:0] pkg_idx,
                            int fixed_body, int n_flags);
    logic [7:0] plain[$];
    logic [7:0] cks;
    logic [7:0] bad;
    int         cut;
    plain = {id[15:8], id[7:0], props[15:8], props[7:0]};
    for (int i = 5; i >= 0; i--) plain.push_back(term[8*i +: 8]);
    plain.push_back(serial[15:8]);
    plain.push_back(serial[7:0]);
    if (props[SUBPKG_BIT]) begin
      plain.push_back(pkg_cnt[15:8]);
      plain.push_back(pkg_cnt[7:0]);
      plain.push_back(pkg_idx[15:8]);
      plain.push_back(pkg_idx[7:0]);
    end
    for (int i = 0; i < props[LEN_W-1:0]; i++)
      plain.push_back(fixed_body >= 0 ? 8'(fixed_body) : body_pick());
    cks = 8'h00;
    foreach (plain[i]) cks ^= plain[i];
    if (fault == FAULT_CHECKSUM) cks ^= 8'($urandom_range(1, 255));
    plain.push_back(cks);

    cut = $urandom_range(0, plain.size() - 1);
    repeat (n_flags) push_byte(FLAG_BYTE);
    foreach (plain[i]) begin
      if (i == cut && fault == FAULT_ESCAPE) begin
        // a flag after a bad escape must reopen a frame at once
        if ($urandom_range(3) == 0) bad = FLAG_BYTE;
        else do bad = 8'($urandom_range(255)); while (bad == ESC_FOR_ESC || bad == ESC_FOR_FLAG);
        push_byte(ESC_BYTE);
        push_byte(bad);
        break;
      end
      if (i == cut && fault == FAULT_TRUNCATE) break;
      push_coded(plain[i]);
    end
  endtask

  task automatic send_random_frame();
    int          pick;
    fault_t      fault;
    logic [15:0] props;
    logic [9:0]  len;
    pick  = $urandom_range(99);
    fault = pick < 72 ? FAULT_NONE : pick < 84 ? FAULT_CHECKSUM :
            pick < 93 ? FAULT_ESCAPE : FAULT_TRUNCATE;
    len   = ($urandom_range(9) == 0) ? 10'($urandom_range(25, 80)) : 10'($urandom_range(0, 12));
    props = 16'($urandom_range(65535));
    props[ENC_BIT] = ($urandom_range(3) == 0);
    props[LEN_W-1:0] = len;
    // noise between frames, ignored while hunting unless it holds a flag
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
    send_frame(fault, 16'($urandom_range(65535)), props,
               {16'($urandom_range(65535)), 32'($urandom)},
               16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), -1, $urandom_range(1, 3));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 12;
    recv_idle = 54;
    set_key(1'b0);

    // escaped id and body, repeated flag, then bad escape and a keyless frame
    send_frame(FAULT_NONE, {FLAG_BYTE, ESC_BYTE}, 16'h0001, 48'hff0123456789,
               {8'h0a, ESC_BYTE}, 16'h0, 16'h0, FLAG_BYTE, 2);
    push_byte(FLAG_BYTE);
    push_byte(ESC_BYTE);
    push_byte(FLAG_BYTE);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h04);
    push_byte(8'h00);

    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin send_idle = 12; recv_idle = 54; end
        1: begin send_idle = 54; recv_idle = 12; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      set_key(seg % 2 == 1);
      while (sent < 25 + 232 * (seg + 1)) send_random_frame();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Fed %0d stream bytes in clean, faulty and noisy frames, key loaded and not.",
             bytes_seen);
    $display("Checked %0d body bytes, %0d completed frames and %0d error reports.",
             body_seen, done_seen, error_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
